>>> design/sep_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// sep_pkg: shared types and constants
// Opcodes, result kinds and payload words of the call event profiler.
// ---------------------------------------------------------------------------
package sep_pkg;

  localparam int FilterDepthDefault  = 64;
  localparam int SummaryDepthDefault = 128;

  typedef enum logic [1:0] {
    OP_ENTRY  = 2'd0,
    OP_EXIT   = 2'd1,
    OP_FILTER = 2'd2,
    OP_READ   = 2'd3
  } op_t;

  localparam logic [1:0] KIND_RECORD  = 2'd0;
  localparam logic [1:0] KIND_SUMMARY = 2'd1;
  localparam logic [1:0] KIND_FILTER  = 2'd2;

  localparam logic [1:0] REG_SUMMARY_MODE = 2'd0;
  localparam logic [1:0] REG_TRACE_FD     = 2'd1;
  localparam logic [1:0] REG_WRITE_CALL   = 2'd2;

  typedef struct packed {
    logic [1:0]         operation;
    logic [8:0]         call_number;
    logic [15:0]        first_arg;
    logic signed [47:0] result_value;
    logic [55:0]        event_time_ns;
    logic [55:0]        reported_duration_ns;
    logic [6:0]         summary_index;
  } in_word_t;

  typedef struct packed {
    logic [1:0]         kind;
    logic [8:0]         out_number;
    logic signed [47:0] out_result;
    logic [55:0]        out_duration_ns;
    logic               entry_valid;
    logic [31:0]        total_calls;
    logic [31:0]        total_errors;
    logic [55:0]        total_bytes;
    logic [55:0]        total_duration_ns;
    logic               add_status;
  } out_word_t;

  // front to back command
  typedef struct packed {
    logic [1:0]         op;
    logic [8:0]         number;
    logic signed [47:0] result;
    logic [55:0]        duration;
    logic [6:0]         index;
    logic               dropped;
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_WRITE,
    ST_EMIT
  } back_state_t;

endpackage
`default_nettype wire

>>> design/sep_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// sep_ram: generic single-port-write ram
// One write port and one read port with registered read data.
// ---------------------------------------------------------------------------
module sep_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] waddr,
  input  wire logic [Width-1:0]         wdata,
  input  wire logic [$clog2(Depth)-1:0] raddr,
  output logic      [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

>>> design/sep_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// sep_front: event pairing front end
// Pairs entries with exits, computes duration and descriptor drop.
// ---------------------------------------------------------------------------
module sep_front
  import sep_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire in_word_t           in_word,
  input  wire logic               in_fire,
  input  wire logic signed [16:0] trace_fd,
  input  wire logic [8:0]         write_call_number,
  output logic                    cmd_push,
  output cmd_t                    cmd
);
  logic        pending_valid;
  logic [8:0]  pending_number;
  logic [15:0] pending_first_arg;
  logic [55:0] pending_time;
  logic [8:0]  number;
  logic [15:0] arg;
  logic [55:0] duration;

  always_comb begin
    number = pending_valid ? pending_number : in_word.call_number;
    arg    = pending_valid ? pending_first_arg : in_word.first_arg;
    if (pending_valid && in_word.event_time_ns >= pending_time) begin
      duration = in_word.event_time_ns - pending_time;
    end else begin
      duration = in_word.reported_duration_ns;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending_valid <= 1'b0;
    end else if (in_fire) begin
      if (in_word.operation == OP_ENTRY) begin
        pending_valid <= 1'b1;
      end else if (in_word.operation == OP_EXIT) begin
        pending_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && in_word.operation == OP_ENTRY) begin
      pending_number    <= in_word.call_number;
      pending_first_arg <= in_word.first_arg;
      pending_time      <= in_word.event_time_ns;
    end
  end

  always_comb begin
    cmd_push     = in_fire && (in_word.operation != OP_ENTRY);
    cmd.op       = in_word.operation;
    cmd.number   = (in_word.operation == OP_EXIT) ? number : in_word.call_number;
    cmd.result   = in_word.result_value;
    cmd.duration = duration;
    cmd.index    = in_word.summary_index;
    cmd.dropped  = !trace_fd[16] && number == write_call_number
                   && {1'b0, arg} == trace_fd;
  end
endmodule
`default_nettype wire

>>> design/sep_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// sep_queue: two-entry command queue
// Decouples the front end from the table engine.
// ---------------------------------------------------------------------------
module sep_queue
  import sep_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  wire cmd_t push_cmd,
  input  wire logic pop,
  output logic      not_empty,
  output logic      has_room,
  output cmd_t      head
);
  cmd_t       slots [2];
  logic       rd_ptr;
  logic       wr_ptr;
  logic [1:0] count;

  assign not_empty = count != 2'd0;
  assign has_room  = count != 2'd2;
  assign head      = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end
endmodule
`default_nettype wire

>>> design/sep_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// sep_back: table engine
// Filter check, summary search and update, slot reads, result register.
// ---------------------------------------------------------------------------
module sep_back
  import sep_pkg::*;
#(
  parameter int FilterDepth  = FilterDepthDefault,
  parameter int SummaryDepth = SummaryDepthDefault
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic summary_mode,
  input  wire logic cmd_valid,
  input  wire cmd_t cmd,
  output logic      cmd_pop,
  output logic      out_valid,
  input  wire logic out_ready,
  output out_word_t out_word
);
  localparam int FW = $clog2(FilterDepth + 1);
  localparam int SW = $clog2(SummaryDepth + 1);
  localparam int FA = (FilterDepth > 1) ? $clog2(FilterDepth) : 1;
  localparam int SA = (SummaryDepth > 1) ? $clog2(SummaryDepth) : 1;
  localparam int RecW = 32 + 32 + 56 + 56;
  localparam logic [31:0] Max32 = '1;
  localparam logic [55:0] Max56 = '1;

  back_state_t state, state_next;
  cmd_t        cur;
  logic [FW-1:0] filter_used;
  logic [SW-1:0] slots_used;
  logic [8:0]  filter_tag [FilterDepth];
  logic [8:0]  slot_tag [SummaryDepth];
  logic [SW-1:0] hit_slot;
  logic          hit;
  logic          filter_pass;
  logic [SA-1:0] ram_waddr;
  logic [SA-1:0] ram_raddr;
  logic [RecW-1:0] ram_wdata;
  logic [RecW-1:0] ram_rdata;
  logic            ram_we;
  logic [31:0] r_calls, r_errors, n_calls, n_errors;
  logic [55:0] r_bytes, r_dur, n_bytes, n_dur;
  logic [56:0] bytes_sum, dur_sum;
  logic        fresh;
  logic        do_account;
  logic        emit_rec;
  logic        read_hit;
  logic        emit_go;
  out_word_t   emit_word;

  // tag compares over flip-flop tags, each entry read at its own place
  always_comb begin
    filter_pass = (filter_used == '0);
    for (int i = 0; i < FilterDepth; i++) begin
      if (FW'(i) < filter_used && filter_tag[i] == cur.number) begin
        filter_pass = 1'b1;
      end
    end
    hit      = 1'b0;
    hit_slot = slots_used;
    for (int i = SummaryDepth - 1; i >= 0; i--) begin
      if (SW'(i) < slots_used && slot_tag[i] == cur.number) begin
        hit      = 1'b1;
        hit_slot = SW'(i);
      end
    end
  end

  assign do_account = !cur.dropped && filter_pass && summary_mode
                      && (hit || slots_used < SW'(SummaryDepth));
  assign emit_rec   = !cur.dropped && filter_pass && !summary_mode;
  assign read_hit   = 32'(cur.index) < 32'(slots_used)
                      && 32'(cur.index) < 32'(SummaryDepth);
  assign emit_go    = (state == ST_EMIT) && (!out_valid || out_ready);

  assign ram_raddr = (cur.op == OP_READ) ? SA'(cur.index) : SA'(hit_slot);
  assign {r_calls, r_errors, r_bytes, r_dur} = ram_rdata;

  always_comb begin
    fresh     = !hit;
    n_calls   = fresh ? 32'd0 : r_calls;
    n_errors  = fresh ? 32'd0 : r_errors;
    n_bytes   = fresh ? 56'd0 : r_bytes;
    n_dur     = fresh ? 56'd0 : r_dur;
    n_calls   = (n_calls == Max32) ? Max32 : n_calls + 32'd1;
    bytes_sum = {1'b0, n_bytes} + 57'({8'd0, cur.result});
    dur_sum   = {1'b0, n_dur} + {1'b0, cur.duration};
    if (cur.result[47]) begin
      n_errors = (n_errors == Max32) ? Max32 : n_errors + 32'd1;
    end else begin
      n_bytes = bytes_sum[56] ? Max56 : bytes_sum[55:0];
    end
    n_dur     = dur_sum[56] ? Max56 : dur_sum[55:0];
    ram_wdata = {n_calls, n_errors, n_bytes, n_dur};
    ram_waddr = SA'(hit_slot);
    ram_we    = (state == ST_WRITE) && do_account;
  end

  sep_ram #(.Width(RecW), .Depth(SummaryDepth)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:   if (cmd_valid) state_next = ST_SEARCH;
      ST_SEARCH: begin
        if (cur.op == OP_EXIT && !emit_rec) begin
          state_next = ST_WRITE;
        end else begin
          state_next = ST_EMIT;
        end
      end
      ST_WRITE:  state_next = ST_IDLE;
      ST_EMIT:   if (!out_valid || out_ready) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_pop = (state == ST_IDLE) && cmd_valid;
  end

  always_comb begin
    emit_word = '0;
    case (cur.op)
      OP_FILTER: begin
        emit_word.kind       = KIND_FILTER;
        emit_word.add_status = filter_used >= FW'(FilterDepth);
      end
      OP_READ: begin
        emit_word.kind = KIND_SUMMARY;
        if (read_hit) begin
          emit_word.entry_valid       = 1'b1;
          emit_word.out_number        = slot_tag[SA'(cur.index)];
          emit_word.total_calls       = r_calls;
          emit_word.total_errors      = r_errors;
          emit_word.total_bytes       = r_bytes;
          emit_word.total_duration_ns = r_dur;
        end
      end
      default: begin
        emit_word.kind            = KIND_RECORD;
        emit_word.out_number      = cur.number;
        emit_word.out_result      = cur.result;
        emit_word.out_duration_ns = cur.duration;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      filter_used <= '0;
      slots_used  <= '0;
      out_valid   <= 1'b0;
    end else begin
      state <= state_next;
      if (emit_go) begin
        out_valid <= 1'b1;
        if (cur.op == OP_FILTER && filter_used < FW'(FilterDepth)) begin
          filter_used <= filter_used + FW'(1);
        end
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (ram_we && !hit) begin
        slots_used <= slots_used + SW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      cur <= cmd;
    end
    if (ram_we && !hit) begin
      slot_tag[SA'(hit_slot)] <= cur.number;
    end
    if (emit_go && cur.op == OP_FILTER && filter_used < FW'(FilterDepth)) begin
      filter_tag[FA'(filter_used)] <= cur.number;
    end
    if (emit_go) begin
      out_word <= emit_word;
    end
  end
endmodule
`default_nettype wire

>>> design/syscall_event_profiler.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// syscall_event_profiler: call event profiler top level
// Front end pairs events, a two-word queue feeds the table engine.
// ---------------------------------------------------------------------------
// In the table engine a word is first taken from the queue, then goes through
// the tag compare and the summary ram read, then through the
// read-modify-write or the result register; a word with a result waits there
// as long as the previous result is still held back by out_ready. Entries
// are handled in the front end only, and the queue takes two words while
// the engine is busy. No clearing pass follows reset.
module syscall_event_profiler
  import sep_pkg::*;
#(
  parameter int FilterDepth  = FilterDepthDefault,
  parameter int SummaryDepth = SummaryDepthDefault
) (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire in_word_t  in_data,
  output logic           out_valid,
  input  wire logic      out_ready,
  output out_word_t      out_data,
  input  wire logic      cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [16:0] cfg_data
);
  logic               summary_mode;
  logic signed [16:0] trace_fd;
  logic [8:0]         write_call_number;
  logic in_fire, cmd_push, q_valid, q_room, q_pop;
  cmd_t cmd, q_head;

  always_ff @(posedge clk) begin
    if (rst) begin
      summary_mode      <= 1'b0;
      trace_fd          <= -17'sd1;
      write_call_number <= 9'd1;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SUMMARY_MODE: summary_mode      <= cfg_data[0];
        REG_TRACE_FD:     trace_fd          <= cfg_data;
        REG_WRITE_CALL:   write_call_number <= cfg_data[8:0];
        default: ;
      endcase
    end
  end

  assign in_ready = q_room;
  assign in_fire  = in_valid && in_ready;

  sep_front u_front (
    .clk(clk), .rst(rst), .in_word(in_data), .in_fire(in_fire),
    .trace_fd(trace_fd), .write_call_number(write_call_number),
    .cmd_push(cmd_push), .cmd(cmd)
  );

  sep_queue u_queue (
    .clk(clk), .rst(rst), .push(cmd_push), .push_cmd(cmd), .pop(q_pop),
    .not_empty(q_valid), .has_room(q_room), .head(q_head)
  );

  sep_back #(.FilterDepth(FilterDepth), .SummaryDepth(SummaryDepth)) u_back (
    .clk(clk), .rst(rst), .summary_mode(summary_mode), .cmd_valid(q_valid),
    .cmd(q_head), .cmd_pop(q_pop), .out_valid(out_valid),
    .out_ready(out_ready), .out_word(out_data)
  );

`ifndef ASSERT_OFF
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result dropped while stalled");
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    cmd_push |-> q_room)
    else $error("queue push while full");
  a_pop_valid: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> q_valid)
    else $error("queue pop while empty");
`endif
endmodule
`default_nettype wire

>>> tb/tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb: call event profiler testbench
// Directed table then random entry/exit pairs, filters and slot reads,
// checked word by word against a behavioral profiler with random idling.
// ---------------------------------------------------------------------------
module tb
  import sep_pkg::*;
;

  localparam int NumFilters = 64;
  localparam int NumSlots   = 128;
  localparam logic [55:0] Max56 = 56'hFF_FFFF_FFFF_FFFF;
  localparam logic [31:0] Max32 = 32'hFFFF_FFFF;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  in_word_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_word_t out_data;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [16:0] cfg_data = '0;

  always #5 clk = ~clk;

  syscall_event_profiler u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // profiler state as the block should hold it
  logic mode_summary;
  logic signed [16:0] own_fd;
  logic [8:0] write_num;
  logic pend_valid;
  logic [8:0] pend_num;
  logic [15:0] pend_arg;
  logic [55:0] pend_ts;
  logic [8:0] filters [NumFilters];
  int filter_cnt;
  logic [8:0] slot_num [NumSlots];
  logic [31:0] slot_calls [NumSlots];
  logic [31:0] slot_errs [NumSlots];
  logic [55:0] slot_bytes [NumSlots];
  logic [55:0] slot_dur [NumSlots];
  int slot_cnt;

  out_word_t expected_words [$];
  int mismatches = 0;
  int idle_pct = 37;
  bit hold_off = 1'b0;

  function automatic logic [55:0] sat56(logic [55:0] a, logic [55:0] b);
    logic [56:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[56] ? Max56 : s[55:0];
  endfunction

  function automatic logic [31:0] inc32(logic [31:0] a);
    return (a == Max32) ? Max32 : a + 32'd1;
  endfunction

  task automatic tally_call(logic [8:0] num, logic [47:0] res, logic [55:0] dur);
    int i;
    i = 0;
    while (i < slot_cnt && slot_num[i] != num) i++;
    if (i == slot_cnt) begin
      if (slot_cnt >= NumSlots) return;
      slot_num[i] = num;
      slot_calls[i] = '0;
      slot_errs[i] = '0;
      slot_bytes[i] = '0;
      slot_dur[i] = '0;
      slot_cnt++;
    end
    slot_calls[i] = inc32(slot_calls[i]);
    if (res[47]) slot_errs[i] = inc32(slot_errs[i]);
    else slot_bytes[i] = sat56(slot_bytes[i], {8'd0, res});
    slot_dur[i] = sat56(slot_dur[i], dur);
  endtask

  task automatic profile_word(in_word_t w);
    out_word_t o;
    logic [8:0] num;
    logic [15:0] arg;
    logic [55:0] dur;
    bit pass;
    o = '0;
    case (w.operation)
      OP_ENTRY: begin
        pend_valid = 1'b1;
        pend_num = w.call_number;
        pend_arg = w.first_arg;
        pend_ts = w.event_time_ns;
      end
      OP_FILTER: begin
        o.kind = KIND_FILTER;
        if (filter_cnt >= NumFilters) o.add_status = 1'b1;
        else begin
          filters[filter_cnt] = w.call_number;
          filter_cnt++;
        end
        expected_words.push_back(o);
      end
      OP_READ: begin
        o.kind = KIND_SUMMARY;
        if (w.summary_index < slot_cnt) begin
          o.out_number = slot_num[w.summary_index];
          o.entry_valid = 1'b1;
          o.total_calls = slot_calls[w.summary_index];
          o.total_errors = slot_errs[w.summary_index];
          o.total_bytes = slot_bytes[w.summary_index];
          o.total_duration_ns = slot_dur[w.summary_index];
        end
        expected_words.push_back(o);
      end
      default: begin
        num = pend_valid ? pend_num : w.call_number;
        arg = pend_valid ? pend_arg : w.first_arg;
        dur = (pend_valid && w.event_time_ns >= pend_ts) ?
              w.event_time_ns - pend_ts : w.reported_duration_ns;
        pend_valid = 1'b0;
        pass = (filter_cnt == 0);
        for (int i = 0; i < filter_cnt; i++) if (filters[i] == num) pass = 1'b1;
        if (own_fd >= 0 && num == write_num && $signed({1'b0, arg}) == own_fd)
          pass = 1'b0;
        if (pass) begin
          if (mode_summary) tally_call(num, w.result_value, dur);
          else begin
            o.kind = KIND_RECORD;
            o.out_number = num;
            o.out_result = w.result_value;
            o.out_duration_ns = dur;
            expected_words.push_back(o);
          end
        end
      end
    endcase
  endtask

  task automatic write_reg(logic [1:0] idx, logic [16:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_SUMMARY_MODE: mode_summary = val[0];
      REG_TRACE_FD: own_fd = val;
      default: write_num = val[8:0];
    endcase
    @(posedge clk);
  endtask

  task automatic send_word(in_word_t w);
    while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    profile_word(w);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  function automatic in_word_t mk(logic [1:0] op, logic [8:0] num, logic [15:0] arg,
                                  logic [47:0] res, logic [55:0] ts, logic [55:0] rep,
                                  logic [6:0] idx);
    in_word_t w;
    w.operation = op;
    w.call_number = num;
    w.first_arg = arg;
    w.result_value = res;
    w.event_time_ns = ts;
    w.reported_duration_ns = rep;
    w.summary_index = idx;
    return w;
  endfunction

  function automatic in_word_t rand_word(logic [1:0] op, logic [8:0] num);
    return mk(op, num, 16'($urandom),
              ($urandom_range(3) == 0) ? 48'({$urandom, $urandom}) :
                                         48'($signed(12'($urandom))),
              {24'($urandom), $urandom}, ($urandom_range(3) == 0) ? 56'd0 :
              {24'($urandom), $urandom}, 7'($urandom));
  endfunction

  // receiver: random idling plus long hold-off on request
  always @(posedge clk) begin
    if (rst || hold_off) out_ready <= 1'b0;
    else out_ready <= !(idle_pct != 0 && $urandom_range(99) < idle_pct);
  end

  // result checking
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (expected_words.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected word %h", out_data);
      end else begin
        if (out_data !== expected_words[0]) begin
          mismatches++;
          if (mismatches <= 10)
            $display("word mismatch exp %h got %h", expected_words[0], out_data);
        end
        void'(expected_words.pop_front());
      end
    end
  end

  typedef struct {
    in_word_t w;
    bit known;
    out_word_t o;
  } dir_row_t;

  initial begin
    dir_row_t rows [$];
    dir_row_t r;
    out_word_t o;
    logic [8:0] hot [8];
    rst <= 1'b1;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    mode_summary = 1'b0; own_fd = -17'sd1; write_num = 9'd1;
    pend_valid = 1'b0; pend_num = '0; pend_arg = '0; pend_ts = '0;
    filter_cnt = 0; slot_cnt = 0;

    // directed table
    o = '0; o.kind = KIND_SUMMARY;
    r.w = mk(OP_READ, '0, '0, '0, '0, '0, 7'd0); r.known = 1'b1; r.o = o;
    rows.push_back(r);
    r.w = mk(OP_READ, '0, '0, '0, '0, '0, 7'd127); rows.push_back(r);
    o = '0; o.kind = KIND_RECORD; o.out_number = 9'd511; o.out_result = 48'h8000_0000_0000;
    o.out_duration_ns = Max56;
    r.w = mk(OP_EXIT, 9'd511, 16'hFFFF, 48'h8000_0000_0000, Max56, Max56, '0);
    r.o = o; rows.push_back(r);
    r.known = 1'b0;
    r.w = mk(OP_ENTRY, 9'd5, 16'd3, '0, 56'd100, '0, '0); rows.push_back(r);
    r.w = mk(OP_EXIT, 9'd9, 16'd0, 48'h7FFF_FFFF_FFFF, 56'd50, 56'd7, '0); rows.push_back(r);
    r.w = mk(OP_ENTRY, 9'd0, 16'd0, '0, 56'd0, '0, '0); rows.push_back(r);
    r.w = mk(OP_ENTRY, 9'd6, 16'd1, '0, 56'd10, '0, '0); rows.push_back(r);
    r.w = mk(OP_EXIT, 9'd0, 16'd0, 48'd0, Max56, 56'd0, '0); rows.push_back(r);
    r.w = mk(OP_EXIT, 9'd1, 16'd2, 48'd5, 56'd0, 56'd0, '0); rows.push_back(r);
    foreach (rows[i]) begin
      send_word(rows[i].w);
      if (rows[i].known) begin
        void'(expected_words.pop_back());
        expected_words.push_back(rows[i].o);
      end
    end
    drain();

    // trace descriptor drop, a small fd and the largest fd
    write_reg(REG_TRACE_FD, 17'd2);
    write_reg(REG_WRITE_CALL, 17'd1);
    send_word(mk(OP_EXIT, 9'd1, 16'd2, 48'd9, '0, 56'd4, '0));
    send_word(mk(OP_EXIT, 9'd1, 16'd3, 48'd9, '0, 56'd4, '0));
    drain();
    write_reg(REG_TRACE_FD, 17'd65535);
    write_reg(REG_WRITE_CALL, 17'd511);
    send_word(mk(OP_EXIT, 9'd511, 16'hFFFF, 48'd1, '0, 56'd4, '0));
    drain();

    // summary mode with saturation of the duration sum
    write_reg(REG_SUMMARY_MODE, 17'd1);
    send_word(mk(OP_EXIT, 9'd7, '0, 48'h7FFF_FFFF_FFFF, '0, Max56, '0));
    send_word(mk(OP_EXIT, 9'd7, '0, 48'h7FFF_FFFF_FFFF, '0, Max56, '0));
    send_word(mk(OP_EXIT, 9'd7, '0, 48'hFFFF_FFFF_FFFF, '0, 56'd1, '0));
    send_word(mk(OP_READ, '0, '0, '0, '0, '0, 7'd0));

    // random part
    for (int i = 0; i < 8; i++) hot[i] = 9'($urandom);
    for (int phase = 0; phase < 6; phase++) begin
      drain();
      write_reg(REG_SUMMARY_MODE, 17'(phase % 2));
      write_reg(REG_TRACE_FD, (phase == 2) ? 17'h1FFFF : 17'($urandom_range(4)));
      write_reg(REG_WRITE_CALL, (phase == 4) ? 17'd0 : 17'($urandom_range(3)));
      idle_pct = (phase == 3) ? 0 : 37;
      if (phase == 1) begin
        fork
          begin hold_off = 1'b1; repeat (300) @(posedge clk); hold_off = 1'b0; end
        join_none
      end
      for (int n = 0; n < 220; n++) begin
        int pick;
        logic [8:0] num;
        pick = $urandom_range(99);
        num = ($urandom_range(2) == 0) ? 9'($urandom) : hot[$urandom_range(7)];
        if (phase == 5 && n < 150) num = 9'($urandom);
        if (pick < 40) begin
          send_word(rand_word(OP_ENTRY, num));
          send_word(rand_word(OP_EXIT, ($urandom_range(3) == 0) ? 9'($urandom) : num));
        end else if (pick < 55) send_word(rand_word(OP_EXIT, num));
        else if (pick < 63) send_word(rand_word(OP_ENTRY, num));
        else if (pick < 68 && phase >= 3) send_word(rand_word(OP_FILTER, num));
        else if (pick < 90) begin
          in_word_t w;
          w = rand_word(OP_READ, num);
          if (w.summary_index > slot_cnt + 2) w.summary_index = 7'($urandom_range(slot_cnt));
          send_word(w);
        end else send_word(rand_word(OP_EXIT, 9'($urandom)));
      end
    end
    // fill the filter set beyond capacity
    for (int i = 0; i < 70; i++) send_word(rand_word(OP_FILTER, 9'($urandom)));
    drain();
    if (mismatches == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    #20ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule
